// ===== rtl/core/gbn_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Go-Back-N sender package
// Shared types, codes and default sizes for the sender window blocks.
// ----------------------------------------------------------------------------
package gbn_pkg;

	// Default sizes handed to the top-level parameters.
	localparam int WINDOW_MAX_DEF = 16;
	localparam int TIMER_BITS_DEF = 20;

	// Request codes carried in the mode field.
	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_ACK   = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;
	localparam logic [1:0] MODE_STOP  = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_WINDOW_SIZE   = 2'd0;
	localparam logic [1:0] CFG_TOTAL_PACKETS = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

	// Register values after reset.
	localparam logic [4:0]  WINDOW_SIZE_RST   = 5'd4;
	localparam logic [15:0] TOTAL_PACKETS_RST = 16'd100;
	localparam logic [19:0] TIMEOUT_TICKS_RST = 20'd2000;

	// Operation codes of the shared arithmetic unit.
	localparam logic ALU_ADD = 1'b0;
	localparam logic ALU_SUB = 1'b1;

	// One result on its way to the output register.
	typedef struct packed {
		logic [15:0] seq_num;
		logic        retransmit;
		logic        last;
	} gbn_res_t;

endpackage : gbn_pkg
`default_nettype wire

// ===== rtl/core/gbn_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Go-Back-N configuration registers
// Holds the session registers and derives the clamped window and timer load.
// ----------------------------------------------------------------------------
module gbn_cfg #(
	parameter int WINDOW_MAX = 16,
	parameter int TIMER_BITS = 20,
	parameter int CW         = 5
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [19:0]           cfg_data,
	output logic [CW-1:0]              win,
	output logic [15:0]                total,
	output logic [TIMER_BITS-1:0]      tload
);
	import gbn_pkg::*;

	localparam logic [32:0] TMAX = (33'd1 << TIMER_BITS) - 33'd1;

	logic [4:0]  window_size_q;
	logic [15:0] total_packets_q;
	logic [19:0] timeout_ticks_q;
	logic [32:0] t_ext;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q   <= WINDOW_SIZE_RST;
			total_packets_q <= TOTAL_PACKETS_RST;
			timeout_ticks_q <= TIMEOUT_TICKS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WINDOW_SIZE:   window_size_q   <= cfg_data[4:0];
				CFG_TOTAL_PACKETS: total_packets_q <= cfg_data[15:0];
				CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A window above the supported maximum acts as the maximum.
	assign win = (8'(window_size_q) > 8'(WINDOW_MAX)) ? CW'(WINDOW_MAX)
		: CW'(window_size_q);

	assign total = total_packets_q;

	// The timer load saturates to the timer width.
	assign t_ext = 33'(timeout_ticks_q);
	assign tload = (t_ext > TMAX) ? TMAX[TIMER_BITS-1:0] : t_ext[TIMER_BITS-1:0];

endmodule : gbn_cfg
`default_nettype wire

// ===== rtl/core/gbn_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Go-Back-N shared arithmetic unit
// One adder/subtractor reused by every step of the sequencer.
// ----------------------------------------------------------------------------
module gbn_alu #(
	parameter int W = 22
) (
	input  wire logic         op,
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	output logic [W-1:0]      res,
	output logic              neg,
	output logic              zero
);
	import gbn_pkg::*;

	// Operands stay well below half the range, so the top bit is the borrow.
	assign res  = (op == ALU_SUB) ? (a - b) : (a + b);
	assign neg  = res[W-1];
	assign zero = (res == '0);

endmodule : gbn_alu
`default_nettype wire

// ===== rtl/core/gbn_out.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Go-Back-N output register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module gbn_out (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire gbn_pkg::gbn_res_t push_data,
	output logic                   free,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [15:0]            seq_num,
	output logic                   retransmit,
	output logic                   last
);
	import gbn_pkg::*;

	logic     valid_q;
	gbn_res_t data_q;

	// The slot can be refilled in the same cycle that its result leaves.
	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_data;
		end
	end

	assign out_valid  = valid_q;
	assign seq_num    = data_q.seq_num;
	assign retransmit = data_q.retransmit;
	assign last       = data_q.last;

endmodule : gbn_out
`default_nettype wire

// ===== rtl/core/go_back_n_sender_window.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Go-Back-N sender window
// Sequencer that tracks the send window and emits sequence numbers.
// ----------------------------------------------------------------------------
// A start request clears the window and sends new sequence numbers until the
// window or the session total is reached; an acknowledgment inside the
// outstanding range slides the window and sends more; a tick request counts
// the retransmit timer down and, on expiry, resends every outstanding number;
// a stop request halts sending and the timer. All arithmetic runs through a
// single shared adder/subtractor stepped by a small sequencer, so the block
// takes one request at a time and in_ready is high only while the sequencer
// is idle. After acceptance a start runs the limit, window, total, send and
// timer steps; an acknowledgment first runs two range compares, where an
// ignored one ends, and the increment, then the steps of a start; a tick
// counts the timer down and, on expiry, counts and resends the outstanding
// numbers. Each emitted number takes one shared-unit step and waits while the
// output stalls. Stop and requests that are ignored while not running finish
// in the accepting cycle. Results leave through an output register, so the
// next request is taken while the last result of the previous one still waits.
// ----------------------------------------------------------------------------
module go_back_n_sender_window #(
	parameter int WINDOW_MAX = gbn_pkg::WINDOW_MAX_DEF,
	parameter int TIMER_BITS = gbn_pkg::TIMER_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write channel.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [19:0] cfg_data,
	// Request channel.
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [15:0] ack_num,
	// Result channel.
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      seq_num,
	output logic             retransmit,
	output logic             last
);
	import gbn_pkg::*;

	// Width of a window count and of the shared unit. The unit keeps two spare
	// bits above the timer count and the sequence numbers so that its top bit is a borrow.
	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int UW = (TIMER_BITS > 16) ? TIMER_BITS + 2 : 18;

	// Sequencer states.
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_ACK_LO  = 4'd1;
	localparam logic [3:0] S_ACK_HI  = 4'd2;
	localparam logic [3:0] S_ACK_INC = 4'd3;
	localparam logic [3:0] S_LIM     = 4'd4;
	localparam logic [3:0] S_AVW     = 4'd5;
	localparam logic [3:0] S_AVT     = 4'd6;
	localparam logic [3:0] S_SEND    = 4'd7;
	localparam logic [3:0] S_TIMER   = 4'd8;
	localparam logic [3:0] S_TICK    = 4'd9;
	localparam logic [3:0] S_RCNT    = 4'd10;
	localparam logic [3:0] S_RESEND  = 4'd11;

	logic [3:0]            state_q;
	logic [15:0]           window_base_q;
	logic [15:0]           next_seq_q;
	logic [TIMER_BITS-1:0] timer_left_q;
	logic                  timer_on_q;
	logic                  running_q;
	logic [15:0]           ack_q;
	logic [16:0]           lim_q;
	logic [CW-1:0]         cnt_q;
	logic [15:0]           resend_q;

	logic [CW-1:0]         win;
	logic [15:0]           total;
	logic [TIMER_BITS-1:0] tload;

	logic                  alu_op;
	logic [UW-1:0]         alu_a;
	logic [UW-1:0]         alu_b;
	logic [UW-1:0]         alu_res;
	logic                  alu_neg;
	logic                  alu_zero;
	logic [CW-1:0]         cnt_clamp;
	logic                  cnt_last;

	logic                  out_free;
	logic                  push;
	gbn_res_t              push_data;

	gbn_cfg #(
		.WINDOW_MAX (WINDOW_MAX),
		.TIMER_BITS (TIMER_BITS),
		.CW         (CW)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.win       (win),
		.total     (total),
		.tload     (tload)
	);

	gbn_alu #(
		.W (UW)
	) u_alu (
		.op   (alu_op),
		.a    (alu_a),
		.b    (alu_b),
		.res  (alu_res),
		.neg  (alu_neg),
		.zero (alu_zero)
	);

	gbn_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.free       (out_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.seq_num    (seq_num),
		.retransmit (retransmit),
		.last       (last)
	);

	assign in_ready = (state_q == S_IDLE);

	// Operand selection for the shared unit, one operation per state.
	always_comb begin
		alu_op = ALU_SUB;
		alu_a  = '0;
		alu_b  = '0;
		case (state_q)
			S_ACK_LO: begin
				alu_a = UW'(ack_q);
				alu_b = UW'(window_base_q);
			end
			S_ACK_HI: begin
				alu_a = UW'(ack_q);
				alu_b = UW'(next_seq_q);
			end
			S_ACK_INC: begin
				alu_op = ALU_ADD;
				alu_a  = UW'(ack_q);
				alu_b  = UW'(1);
			end
			S_LIM: begin
				alu_op = ALU_ADD;
				alu_a  = UW'(window_base_q);
				alu_b  = UW'(win);
			end
			S_AVW: begin
				alu_a = UW'(lim_q);
				alu_b = UW'(next_seq_q);
			end
			S_AVT: begin
				alu_a = UW'(total);
				alu_b = UW'(next_seq_q);
			end
			S_SEND: begin
				alu_op = ALU_ADD;
				alu_a  = UW'(next_seq_q);
				alu_b  = UW'(1);
			end
			S_TIMER: begin
				alu_a = UW'(window_base_q);
				alu_b = UW'(next_seq_q);
			end
			S_TICK: begin
				alu_a = UW'(timer_left_q);
				alu_b = UW'(1);
			end
			S_RCNT: begin
				alu_a = UW'(next_seq_q);
				alu_b = UW'(window_base_q);
			end
			S_RESEND: begin
				alu_op = ALU_ADD;
				alu_a  = UW'(resend_q);
				alu_b  = UW'(1);
			end
			default: ;
		endcase
	end

	// A difference turned into a count: negative means none, and no more
	// than the window maximum goes out for one request.
	assign cnt_clamp = alu_neg ? '0
		: ((alu_res > UW'(WINDOW_MAX)) ? CW'(WINDOW_MAX) : alu_res[CW-1:0]);

	assign cnt_last = (cnt_q == CW'(1));

	// A result is handed to the output register while the count lasts and
	// the register has room.
	always_comb begin
		push      = 1'b0;
		push_data = '0;
		if (state_q == S_SEND && cnt_q != '0 && out_free) begin
			push                 = 1'b1;
			push_data.seq_num    = next_seq_q;
			push_data.retransmit = 1'b0;
			push_data.last       = cnt_last;
		end else if (state_q == S_RESEND && cnt_q != '0 && out_free) begin
			push                 = 1'b1;
			push_data.seq_num    = resend_q;
			push_data.retransmit = 1'b1;
			push_data.last       = cnt_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			window_base_q <= '0;
			next_seq_q    <= '0;
			timer_left_q  <= '0;
			timer_on_q    <= 1'b0;
			running_q     <= 1'b0;
			cnt_q         <= '0;
			lim_q         <= '0;
			resend_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (mode)
							MODE_START: begin
								running_q     <= 1'b1;
								window_base_q <= '0;
								next_seq_q    <= '0;
								state_q       <= S_LIM;
							end
							MODE_ACK: begin
								if (running_q) begin
									state_q <= S_ACK_LO;
								end
							end
							MODE_TICK: begin
								if (running_q && timer_on_q) begin
									state_q <= S_TICK;
								end
							end
							MODE_STOP: begin
								running_q    <= 1'b0;
								timer_on_q   <= 1'b0;
								timer_left_q <= '0;
							end
							default: ;
						endcase
					end
				end
				// Acknowledgment below the window base is stale.
				S_ACK_LO: begin
					state_q <= alu_neg ? S_IDLE : S_ACK_HI;
				end
				// Acknowledgment at or past the next number was never sent.
				S_ACK_HI: begin
					state_q <= alu_neg ? S_ACK_INC : S_IDLE;
				end
				S_ACK_INC: begin
					window_base_q <= alu_res[15:0];
					state_q       <= S_LIM;
				end
				S_LIM: begin
					lim_q   <= alu_res[16:0];
					state_q <= S_AVW;
				end
				S_AVW: begin
					cnt_q   <= cnt_clamp;
					state_q <= S_AVT;
				end
				S_AVT: begin
					if (alu_neg) begin
						cnt_q <= '0;
					end else if (alu_res < UW'(cnt_q)) begin
						cnt_q <= alu_res[CW-1:0];
					end
					state_q <= S_SEND;
				end
				S_SEND: begin
					if (cnt_q == '0) begin
						state_q <= S_TIMER;
					end else if (out_free) begin
						next_seq_q <= alu_res[15:0];
						cnt_q      <= cnt_q - CW'(1);
						if (cnt_last) begin
							state_q <= S_TIMER;
						end
					end
				end
				// The timer runs only while numbers are outstanding.
				S_TIMER: begin
					if (alu_zero) begin
						timer_on_q   <= 1'b0;
						timer_left_q <= '0;
					end else begin
						timer_on_q   <= 1'b1;
						timer_left_q <= tload;
					end
					state_q <= S_IDLE;
				end
				// A timer at one or zero expires on this tick.
				S_TICK: begin
					if (!alu_neg && !alu_zero) begin
						timer_left_q <= alu_res[TIMER_BITS-1:0];
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_RCNT;
					end
				end
				S_RCNT: begin
					cnt_q    <= cnt_clamp;
					resend_q <= window_base_q;
					state_q  <= S_RESEND;
				end
				S_RESEND: begin
					if (cnt_q == '0) begin
						timer_left_q <= tload;
						state_q      <= S_IDLE;
					end else if (out_free) begin
						resend_q <= alu_res[15:0];
						cnt_q    <= cnt_q - CW'(1);
						if (cnt_last) begin
							timer_left_q <= tload;
							state_q      <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The acknowledged number is kept for the compare steps.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ack_q <= ack_num;
		end
	end

endmodule : go_back_n_sender_window
`default_nettype wire
